// ===== rtl/lpbd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpbd_pkg
// Shared types and constants of the length-prefixed bit deframer.
// ----------------------------------------------------------------------------
package lpbd_pkg;

  localparam int unsigned SenderW       = 22;
  localparam int unsigned HeaderCountW  = 4;
  localparam int unsigned LengthW       = 32;
  localparam int unsigned BodyCountW    = 31;
  localparam int unsigned HeaderDigitsDefault = 10;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam logic [LengthW+2:0] LengthMax = 35'h0_7FFF_FFFF;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_NON_DIGIT  = 2'd1,
    ERR_TOO_LONG   = 2'd2,
    ERR_NO_TERM    = 2'd3
  } err_e;

  typedef struct packed {
    err_e               error_code;
    logic               message_done;
    logic [7:0]         payload_byte;
    logic               byte_valid;
    logic [SenderW-1:0] ack_target;
    logic               ack_valid;
  } result_t;

endpackage

// ===== rtl/lpbd_core.sv =====
// ----------------------------------------------------------------------------
// lpbd_core
// Deframer state and the single-pass update for one received bit.
// ----------------------------------------------------------------------------
module lpbd_core #(
  parameter int unsigned HeaderDigits = lpbd_pkg::HeaderDigitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [lpbd_pkg::SenderW-1:0] sender_id_i,
  input  logic                         bit_value_i,
  output lpbd_pkg::result_t            result_o
);

  localparam logic [lpbd_pkg::HeaderCountW-1:0] LastHeader =
    lpbd_pkg::HeaderCountW'(HeaderDigits);

  logic [lpbd_pkg::SenderW-1:0]      locked_q, locked_d;
  logic [2:0]                        bit_index_q, bit_index_d;
  logic [7:0]                        byte_shift_q, byte_shift_d;
  logic                              in_body_q, in_body_d;
  logic [lpbd_pkg::HeaderCountW-1:0] header_count_q, header_count_d;
  logic [lpbd_pkg::LengthW-1:0]      length_q, length_d;
  lpbd_pkg::err_e                    header_bad_q, header_bad_d;
  logic [lpbd_pkg::BodyCountW-1:0]   body_count_q, body_count_d;

  logic [lpbd_pkg::SenderW-1:0]  lock_eff;
  logic                          match;
  logic [7:0]                    shifted;
  logic                          is_digit;
  logic [lpbd_pkg::LengthW+2:0]  length_next;

  assign lock_eff = (locked_q == '0) ? sender_id_i : locked_q;
  assign match    = (sender_id_i != '0) && (sender_id_i == lock_eff);
  assign shifted  = byte_shift_q | (8'(bit_value_i) << bit_index_q);
  assign is_digit = (shifted >= lpbd_pkg::AsciiZero) && (shifted <= lpbd_pkg::AsciiNine);
  // Multiply by twelve as two shifts (times eight plus times four), then add the digit value.
  assign length_next = {length_q, 3'b000} + {1'b0, length_q, 2'b00}
                     + {27'd0, shifted - lpbd_pkg::AsciiZero};

  always_comb begin
    locked_d       = locked_q;
    bit_index_d    = bit_index_q;
    byte_shift_d   = byte_shift_q;
    in_body_d      = in_body_q;
    header_count_d = header_count_q;
    length_d       = length_q;
    header_bad_d   = header_bad_q;
    body_count_d   = body_count_q;
    result_o       = '0;

    if (step_i && match) begin
      result_o.ack_valid  = 1'b1;
      result_o.ack_target = lock_eff;
      locked_d            = lock_eff;
      if (bit_index_q != 3'd7) begin
        bit_index_d  = bit_index_q + 3'd1;
        byte_shift_d = shifted;
      end else begin
        bit_index_d  = '0;
        byte_shift_d = '0;
        if (!in_body_q) begin
          if (!is_digit) begin
            header_bad_d = lpbd_pkg::ERR_NON_DIGIT;
          end else if (header_bad_q == lpbd_pkg::ERR_NONE) begin
            if (length_next > lpbd_pkg::LengthMax) begin
              header_bad_d = lpbd_pkg::ERR_TOO_LONG;
            end else begin
              length_d = length_next[lpbd_pkg::LengthW-1:0];
            end
          end
          header_count_d = header_count_q + lpbd_pkg::HeaderCountW'(1);
          if (header_count_d >= LastHeader) begin
            if (header_bad_d != lpbd_pkg::ERR_NONE) begin
              result_o.error_code = header_bad_d;
              locked_d       = '0;
              header_count_d = '0;
              length_d       = '0;
              header_bad_d   = lpbd_pkg::ERR_NONE;
              body_count_d   = '0;
            end else begin
              in_body_d      = 1'b1;
              body_count_d   = '0;
              header_count_d = '0;
            end
          end
        end else if ({1'b0, body_count_q} < length_q) begin
          result_o.byte_valid   = 1'b1;
          result_o.payload_byte = shifted;
          body_count_d          = body_count_q + lpbd_pkg::BodyCountW'(1);
        end else begin
          // Terminator byte: the message ends either way.
          if (shifted == 8'd0) begin
            result_o.message_done = 1'b1;
          end else begin
            result_o.error_code = lpbd_pkg::ERR_NO_TERM;
          end
          locked_d       = '0;
          in_body_d      = 1'b0;
          header_count_d = '0;
          length_d       = '0;
          header_bad_d   = lpbd_pkg::ERR_NONE;
          body_count_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q       <= '0;
      bit_index_q    <= '0;
      byte_shift_q   <= '0;
      in_body_q      <= 1'b0;
      header_count_q <= '0;
      length_q       <= '0;
      header_bad_q   <= lpbd_pkg::ERR_NONE;
      body_count_q   <= '0;
    end else begin
      locked_q       <= locked_d;
      bit_index_q    <= bit_index_d;
      byte_shift_q   <= byte_shift_d;
      in_body_q      <= in_body_d;
      header_count_q <= header_count_d;
      length_q       <= length_d;
      header_bad_q   <= header_bad_d;
      body_count_q   <= body_count_d;
    end
  end

endmodule

// ===== rtl/length_prefixed_bit_deframer_unit.sv =====
// An accepted item passes through the input register and then the result register before its result shows.
// Throughput: one item per cycle while the result side is ready; the state update for a bit is a single pass of logic.
// The result register decouples the sides, so input is taken into an empty input register while a result waits.
// Reset: asynchronous, active low; the block is unlocked, in header phase, with no item held.
// ----------------------------------------------------------------------------
// length_prefixed_bit_deframer_unit
// Deframes LSB-first bits from one locked sender into a length-prefixed message.
// ----------------------------------------------------------------------------
module length_prefixed_bit_deframer_unit #(
  parameter int unsigned HeaderDigits = lpbd_pkg::HeaderDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // sender_id[21:0], bit_value[22], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // ack_valid, ack_target[22], byte_valid,
                                      // payload_byte[8], message_done, error_code[2]
);

  logic                         in_valid_q;
  logic [lpbd_pkg::SenderW-1:0] sender_q;
  logic                         bit_q;
  logic                         out_valid_q;
  lpbd_pkg::result_t            res_q;
  lpbd_pkg::result_t            res_d;
  logic                         advance;

  // An item moves into the result register whenever that register is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  lpbd_core #(
    .HeaderDigits(HeaderDigits)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .sender_id_i(sender_q),
    .bit_value_i(bit_q),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      sender_q <= s_axis_tdata[lpbd_pkg::SenderW-1:0];
      bit_q    <= s_axis_tdata[lpbd_pkg::SenderW];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, res_q.error_code, res_q.message_done, res_q.payload_byte,
                          res_q.byte_valid, res_q.ack_target, res_q.ack_valid};

endmodule
